// ===== rtl/text_console_buffer_assert.svh =====
// ----------------------------------------------------------------------------
// text_console_buffer_assert.svh
// Assertion macros for the console buffer; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define TCB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define TCB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`else

`define TCB_ASSERT_IMP(lbl, ante, cons, msg)
`define TCB_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg
// Screen geometry, key codes and shared types of the console buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcb_pkg;

	localparam int ROWS   = 16;
	localparam int COLS   = 32;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = 1 << ADDR_W;

	localparam int CHAR_W = 8;
	localparam int OCOL_W = 5;
	localparam int OROW_W = 4;
	localparam int MASK_W = 16;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

	localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h7F;
	localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] KEY_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] BLANK         = 8'h20;

	typedef enum logic [1:0] {
		CMD_PUT,
		CMD_READ,
		CMD_CLR_DIRTY,
		CMD_CLR_SCREEN
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_data;
		logic [OCOL_W-1:0] cursor_col;
		logic [OROW_W-1:0] cursor_row;
		logic [MASK_W-1:0] dirty_mask;
	} res_t;

	// logical row to physical row of the circular row store
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
	                                              input logic [ROW_W-1:0] base);
		logic [ROW_W:0] sum;
		sum = {1'b0, lrow} + {1'b0, base};
		if (sum >= (ROW_W+1)'(ROWS))
			sum = sum - (ROW_W+1)'(ROWS);
		return sum[ROW_W-1:0];
	endfunction

endpackage

// ===== rtl/tcb_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcb_cell_ram
// Character cell store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcb_cell_ram (
	input  logic                               clk,
	input  tcb_pkg::mem_req_t                  req,
	output logic [tcb_pkg::CHAR_W-1:0]         rd_data
);
	import tcb_pkg::*;

	logic [CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		rd_data <= mem[req.raddr];
	end

endmodule

// ===== rtl/tcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcb_ctrl
// Command sequencer: cursor, row base, dirty bits and blanking sweeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  cmd,
	input  logic [7:0]                  char_code,
	input  logic [3:0]                  row_sel,
	input  logic [4:0]                  col_sel,
	input  logic                        input_mode,
	output tcb_pkg::mem_req_t           mem_req,
	input  logic [tcb_pkg::CHAR_W-1:0]  rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output tcb_pkg::res_t               res
);
	import tcb_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_SWEEP,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  base_q;
	logic [ROWS-1:0]   dirty_q;
	logic [CHAR_W-1:0] data_q;
	logic              rd_ok_q;
	logic [ROW_W-1:0]  sw_row_q;
	logic [COL_W-1:0]  sw_col_q;
	logic              sw_all_q;

	cmd_t              cmd_e;
	logic              accept;
	logic              rd_ok;
	logic              row_ok;
	logic [ROW_W-1:0]  sel_row;
	logic [COL_W-1:0]  sel_col;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_lrow;
	logic [COL_W-1:0]  wr_col;
	logic [CHAR_W-1:0] wr_data;
	logic [ROW_W-1:0]  nx_row;
	logic [COL_W-1:0]  nx_col;
	logic              mark_en;
	logic [ROW_W-1:0]  mark_row;
	logic              adv_row;
	logic              scroll;
	logic              sw_end;

	assign cmd_e   = cmd_t'(cmd);
	assign accept  = in_valid && (state_q == ST_IDLE);
	assign sel_row = ROW_W'(row_sel);
	assign sel_col = COL_W'(col_sel);
	assign row_ok  = 32'(row_sel) < 32'(ROWS);
	assign rd_ok   = row_ok && (32'(col_sel) < 32'(COLS));
	assign sw_end  = (sw_col_q == COL_LAST) && (!sw_all_q || sw_row_q == ROW_LAST);

	// put command decode
	always_comb begin
		wr_en    = 1'b0;
		wr_lrow  = cur_row_q;
		wr_col   = cur_col_q;
		wr_data  = char_code;
		nx_row   = cur_row_q;
		nx_col   = cur_col_q;
		mark_en  = 1'b0;
		mark_row = cur_row_q;
		adv_row  = 1'b0;
		scroll   = 1'b0;
		case (cmd_e)
			CMD_PUT: begin
				if (char_code == KEY_BACKSPACE) begin
					if (cur_col_q == '0) begin
						if (cur_row_q != '0) begin
							nx_row   = cur_row_q - ROW_W'(1);
							nx_col   = COL_LAST;
							wr_en    = 1'b1;
							wr_lrow  = nx_row;
							wr_col   = COL_LAST;
							wr_data  = BLANK;
							mark_en  = 1'b1;
							mark_row = nx_row;
						end
					end else begin
						nx_col  = cur_col_q - COL_W'(1);
						wr_en   = 1'b1;
						wr_col  = nx_col;
						wr_data = BLANK;
						mark_en = 1'b1;
					end
				end else if (char_code == KEY_NEWLINE) begin
					adv_row = 1'b1;
				end else if (char_code == KEY_RETURN) begin
					nx_col  = '0;
					mark_en = 1'b1;
				end else begin
					wr_en   = 1'b1;
					mark_en = 1'b1;
					if (cur_col_q == COL_LAST)
						adv_row = 1'b1;
					else
						nx_col = cur_col_q + COL_W'(1);
				end
			end
			default: ;
		endcase
		if (adv_row) begin
			nx_col = '0;
			if (cur_row_q == ROW_LAST)
				scroll = 1'b1;
			else
				nx_row = cur_row_q + ROW_W'(1);
		end
	end

	always_comb begin
		mem_req.raddr = {phys_row(sel_row, base_q), sel_col};
		if (state_q == ST_INIT || state_q == ST_SWEEP) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = {sw_row_q, sw_col_q};
			mem_req.wdata = BLANK;
		end else begin
			mem_req.we    = accept && wr_en;
			mem_req.waddr = {phys_row(wr_lrow, base_q), wr_col};
			mem_req.wdata = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cur_row_q <= '0;
			cur_col_q <= '0;
			base_q    <= '0;
			dirty_q   <= '0;
			sw_row_q  <= '0;
			sw_col_q  <= '0;
			sw_all_q  <= 1'b1;
			data_q    <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (state_q == ST_INIT || state_q == ST_SWEEP) begin
				if (sw_col_q == COL_LAST) begin
					sw_col_q <= '0;
					sw_row_q <= (sw_row_q == ROW_LAST) ? '0 : sw_row_q + ROW_W'(1);
				end else begin
					sw_col_q <= sw_col_q + COL_W'(1);
				end
			end
			case (state_q)
				ST_INIT: begin
					if (sw_end)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						data_q  <= '0;
						rd_ok_q <= rd_ok;
						case (cmd_e)
							CMD_PUT: begin
								cur_row_q <= nx_row;
								cur_col_q <= nx_col;
								if (scroll) begin
									// old top row becomes the new bottom row
									dirty_q  <= '1;
									base_q   <= phys_row(ROW_W'(1), base_q);
									sw_row_q <= base_q;
									sw_col_q <= '0;
									sw_all_q <= 1'b0;
									state_q  <= ST_SWEEP;
								end else begin
									if (mark_en)
										dirty_q[mark_row] <= 1'b1;
									state_q <= ST_DONE;
								end
							end
							CMD_READ: state_q <= ST_RD;
							CMD_CLR_DIRTY: begin
								if (row_ok)
									dirty_q[sel_row] <= 1'b0;
								state_q <= ST_DONE;
							end
							CMD_CLR_SCREEN: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
								sw_row_q  <= '0;
								sw_col_q  <= '0;
								sw_all_q  <= 1'b1;
								state_q   <= ST_SWEEP;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD: begin
					data_q  <= rd_ok_q ? rd_data : '0;
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (sw_end)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.cell_data  = data_q;
		res.cursor_col = OCOL_W'(cur_col_q);
		res.cursor_row = OROW_W'(cur_row_q);
		res.dirty_mask = '0;
		for (int r = 0; r < MASK_W; r++) begin
			if (r < ROWS)
				res.dirty_mask[r] = dirty_q[r] || (input_mode && cur_row_q == ROW_W'(r));
		end
	end

endmodule

// ===== rtl/text_console_buffer.sv =====
// ----------------------------------------------------------------------------
// text_console_buffer
// Character terminal screen buffer with cursor, scrolling and dirty rows.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------
//  in       | cmd, char_code, row_sel, col_sel          | in_valid/in_stall
//  cfg      | cfg_data (input_mode)                     | cfg_valid/cfg_ready
//  out      | cell_data, cursor_col, cursor_row, mask   | out_valid/out_stall
//
//  Put and clear-dirty go from idle straight to the result; a cell read
//  first passes a read state for the registered RAM read. Scroll blanks
//  the bottom row through the RAM write port; clear screen sweeps every cell.
//  After reset the cell RAM is blanked by the same sweep with in_stall high.
//  One result beat is held in the output register; a new item is taken
//  while it waits, and a full register stalls the sequencer at its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_buffer_assert.svh"

module text_console_buffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	input  logic [3:0]  row_sel,
	input  logic [4:0]  col_sel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  cell_data,
	output logic [4:0]  cursor_col,
	output logic [3:0]  cursor_row,
	output logic [15:0] dirty_mask
);
	import tcb_pkg::*;

	logic              input_mode_q;
	mem_req_t          mem_req;
	logic [CHAR_W-1:0] rd_data;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              out_valid_q;
	res_t              res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			input_mode_q <= 1'b0;
		else if (cfg_valid)
			input_mode_q <= cfg_data;
	end

	tcb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.row_sel    (row_sel),
		.col_sel    (col_sel),
		.input_mode (input_mode_q),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	tcb_cell_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && res_ready)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			res_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign cell_data  = res_q.cell_data;
	assign cursor_col = res_q.cursor_col;
	assign cursor_row = res_q.cursor_row;
	assign dirty_mask = res_q.dirty_mask;

	`TCB_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"input accepted but sequencer did not go busy")
	`TCB_ASSERT_NXT(a_result_held, res_valid && !res_ready, res_valid,
		"result dropped while output register was full")
	`TCB_ASSERT_NXT(a_out_drains, out_valid && !out_stall && !res_valid, !out_valid,
		"output beat taken but register stayed valid")

endmodule
